FILE: hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and types of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 4;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHR_W  = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int IDX_W  = 8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CHR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h07;
	localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h0F;

	typedef enum logic {
		OP_PUT   = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_CURSOR = 2'd0,
		KIND_CELL   = 2'd1,
		KIND_SCROLL = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TEXT_ATTR  = 8'd0,
		REG_BLANK_ATTR = 8'd1
	} reg_idx_t;

	typedef struct packed {
		kind_t             kind;
		logic [ROW_W-1:0]  write_row;
		logic [COL_W-1:0]  write_col;
		logic [CELL_W-1:0] cell_value;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0]      num;
		res_t [1:0]      item;
		logic [ROW_W-1:0] next_row;
		logic [COL_W-1:0] next_col;
	} push_t;

endpackage

FILE: hdl/tcce_if.sv
// ----------------------------------------------------------------------------
// tcce_if
// Valid/ready channels of the cursor engine: command, result, configuration.
// ----------------------------------------------------------------------------
interface tcce_cmd_if import tcce_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             operation;
	logic [CHR_W-1:0] character;

	modport source (output valid, operation, character, input ready);
	modport sink   (input valid, operation, character, output ready);
endinterface

interface tcce_res_if import tcce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [ROW_W-1:0]  write_row;
	logic [COL_W-1:0]  write_col;
	logic [CELL_W-1:0] cell_value;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;
	logic              last_of_run;

	modport source (output valid, kind, write_row, write_col, cell_value,
		cursor_row, cursor_col, last_of_run, input ready);
	modport sink   (input valid, kind, write_row, write_col, cell_value,
		cursor_row, cursor_col, last_of_run, output ready);
endinterface

interface tcce_cfg_if import tcce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [ATTR_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tcce_step.sv
// ----------------------------------------------------------------------------
// tcce_step
// Cursor update for one command: next cursor and up to two result beats.
// ----------------------------------------------------------------------------
module tcce_step import tcce_pkg::*; (
	input  logic              operation,
	input  logic [CHR_W-1:0]  character,
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  col,
	input  logic [ATTR_W-1:0] text_attr,
	input  logic [ATTR_W-1:0] blank_attr,
	output push_t             push
);

	logic [COL_W:0]   tab_sum;
	logic [COL_W:0]   tab_col;
	logic             adv;
	logic             wr;
	logic             scr;
	logic [ROW_W-1:0] nrow;
	logic [COL_W-1:0] ncol;
	logic [ROW_W-1:0] wrow;
	logic [COL_W-1:0] wcol;
	logic [CELL_W-1:0] wcell;
	logic [CELL_W-1:0] blank;
	res_t             r_wr;
	res_t             r_scr;
	res_t             r_cur;
	res_t             r_clr;

	assign tab_sum = {1'b0, col} + (COL_W+1)'(TAB_STOP);
	assign tab_col = tab_sum & ~(COL_W+1)'(TAB_STOP - 1);
	assign blank   = {blank_attr, CH_SPACE};

	always_comb begin
		adv   = 1'b0;
		wr    = 1'b0;
		nrow  = row;
		ncol  = col;
		wrow  = row;
		wcol  = col;
		wcell = {text_attr, character};
		case (character)
			CH_LF: begin
				adv = 1'b1;
			end
			CH_CR: begin
				ncol = '0;
			end
			CH_TAB: begin
				ncol = tab_col[COL_W-1:0];
				adv  = (tab_col >= (COL_W+1)'(COLUMNS));
			end
			CH_BS: begin
				wcell = {text_attr, CH_SPACE};
				if (col != '0) begin
					wr   = 1'b1;
					ncol = col - COL_W'(1);
					wcol = col - COL_W'(1);
				end else if (row != '0) begin
					wr   = 1'b1;
					nrow = row - ROW_W'(1);
					ncol = COL_W'(COLUMNS - 1);
					wrow = row - ROW_W'(1);
					wcol = COL_W'(COLUMNS - 1);
				end
			end
			default: begin
				wr   = 1'b1;
				ncol = col + COL_W'(1);
				adv  = (col == COL_W'(COLUMNS - 1));
			end
		endcase
		scr = 1'b0;
		if (adv) begin
			ncol = '0;
			if (row == ROW_W'(ROWS - 1)) begin
				scr = 1'b1;
			end else begin
				nrow = row + ROW_W'(1);
			end
		end
	end

	always_comb begin
		r_wr  = '{KIND_CELL, wrow, wcol, wcell, nrow, ncol, ~scr};
		r_scr = '{KIND_SCROLL, '0, '0, blank, nrow, ncol, 1'b1};
		r_cur = '{KIND_CURSOR, '0, '0, '0, nrow, ncol, 1'b1};
		r_clr = '{KIND_CLEAR, '0, '0, blank, '0, '0, 1'b1};

		push.item[1] = r_scr;
		if (operation == OP_CLEAR) begin
			push.num      = 2'd1;
			push.item[0]  = r_clr;
			push.next_row = '0;
			push.next_col = '0;
		end else if (character == CH_NUL) begin
			push.num      = 2'd0;
			push.item[0]  = r_cur;
			push.next_row = row;
			push.next_col = col;
		end else begin
			push.num      = (wr && scr) ? 2'd2 : 2'd1;
			push.item[0]  = wr ? r_wr : (scr ? r_scr : r_cur);
			push.next_row = nrow;
			push.next_col = ncol;
		end
	end

endmodule

FILE: hdl/tcce_rq.sv
// ----------------------------------------------------------------------------
// tcce_rq
// Result queue: takes up to two beats a cycle, hands out one a cycle on out_ready.
// ----------------------------------------------------------------------------
module tcce_rq import tcce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  push_t push,
	input  logic  push_en,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_item
);

	res_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [1:0]        n_in;
	logic              pop;

	assign n_in      = push_en ? push.num : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_item  = ent_q[rp_q];
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(n_in);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(n_in) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			ent_q[wp_q] <= push.item[0];
		end
		if (n_in == 2'd2) begin
			ent_q[wp_q + QPTR_W'(1)] <= push.item[1];
		end
	end

endmodule

FILE: hdl/text_console_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Text console cursor engine: cursor tracking, cell writes, scroll and clear.
//
//   channel  dir  beat
//   cmd      in   operation, character
//   res      out  kind, write/cursor position, cell_value, last_of_run
//   cfg      in   index, data (attribute registers)
//
// One command is taken per cycle while cmd.ready is high; cursor regs update on that edge.
// A command yields zero, one or two result beats into a four-entry queue; the
// output side drains one beat per cycle while res.ready is high; a scrolling
// write yields two beats. cmd.ready drops when fewer than two entries are free.
// Reset homes the cursor and loads the default attributes; cfg is always ready.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core import tcce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcce_cmd_if.sink   cmd,
	tcce_res_if.source res,
	tcce_cfg_if.sink   cfg
);

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] text_attr_q;
	logic [ATTR_W-1:0] blank_attr_q;
	push_t             push;
	logic              room;
	logic              acc;
	res_t              head;

	assign cmd.ready = room;
	assign acc       = cmd.valid && room;
	assign cfg.ready = 1'b1;

	tcce_step u_step (
		.operation (cmd.operation),
		.character (cmd.character),
		.row       (row_q),
		.col       (col_q),
		.text_attr (text_attr_q),
		.blank_attr(blank_attr_q),
		.push      (push)
	);

	tcce_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_en  (acc),
		.room     (room),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.out_item (head)
	);

	assign res.kind        = head.kind;
	assign res.write_row   = head.write_row;
	assign res.write_col   = head.write_col;
	assign res.cell_value  = head.cell_value;
	assign res.cursor_row  = head.cursor_row;
	assign res.cursor_col  = head.cursor_col;
	assign res.last_of_run = head.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			row_q <= push.next_row;
			col_q <= push.next_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q  <= TEXT_ATTR_RST;
			blank_attr_q <= BLANK_ATTR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TEXT_ATTR:  text_attr_q  <= cfg.data;
				REG_BLANK_ATTR: blank_attr_q <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/tcce_chk.sv
// ----------------------------------------------------------------------------
// tcce_chk
// Port-level checks of the cursor engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_chk import tcce_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [1:0]        res_kind,
	input logic [ROW_W-1:0]  res_write_row,
	input logic [COL_W-1:0]  res_write_col,
	input logic [CELL_W-1:0] res_cell_value,
	input logic [ROW_W-1:0]  res_cursor_row,
	input logic [COL_W-1:0]  res_cursor_col,
	input logic              res_last_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_cell_value) && $stable(res_last_of_run))
		else $error("result beat changed while stalled");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last_of_run |=>
			res_valid && res_kind == KIND_SCROLL && res_last_of_run)
		else $error("first beat of a pair not followed by its scroll");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_CLEAR |->
			res_cursor_row == '0 && res_cursor_col == '0 && res_last_of_run)
		else $error("clear beat without home cursor");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_cursor_row < ROW_W'(ROWS) && res_cursor_col < COL_W'(COLUMNS)
			&& res_write_row < ROW_W'(ROWS) && res_write_col < COL_W'(COLUMNS))
		else $error("position off screen");

endmodule

bind text_console_cursor_engine_core tcce_chk u_tcce_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_kind       (res.kind),
	.res_write_row  (res.write_row),
	.res_write_col  (res.write_col),
	.res_cell_value (res.cell_value),
	.res_cursor_row (res.cursor_row),
	.res_cursor_col (res.cursor_col),
	.res_last_of_run(res.last_of_run)
);
